// ===== rtl/tlru_pkg.sv =====
package tlru_pkg;

    // Field widths of the address split
    localparam int ADDR_W    = 32;
    localparam int OFS_W     = 5;
    localparam int BLK_W     = 27;
    localparam int TAG_W     = 21;
    localparam int SETF_W    = 6;
    localparam int HCNT_W    = 32;
    localparam int BLK_LSB   = 5;
    localparam int TAG_LSB   = 11;
    localparam int DIVCNT_W  = 2;

    // Steps of the set index remainder when the set count is not a power of two
    localparam logic [DIVCNT_W-1:0] MOD_QUOT = 2'd0;
    localparam logic [DIVCNT_W-1:0] MOD_REM  = 2'd1;
    localparam logic [DIVCNT_W-1:0] MOD_FIX  = 2'd2;
    localparam logic [DIVCNT_W-1:0] MOD_DONE = 2'd3;

    // Saturation value of the hit and miss counters
    localparam logic [HCNT_W-1:0] CNT_MAX = {HCNT_W{1'b1}};

    // Fill counts of a set
    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_ONE  = 2'd1;
    localparam logic [1:0] FILL_TWO  = 2'd2;

    // One directory row: both way tags plus fill count and MRU way
    typedef struct packed {
        logic             recent;
        logic [1:0]       filled;
        logic [TAG_W-1:0] tag1;
        logic [TAG_W-1:0] tag0;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // Result item
    typedef struct packed {
        logic [OFS_W-1:0]  byte_offset;
        logic [BLK_W-1:0]  block_number;
        logic [SETF_W-1:0] set_index;
        logic              way_used;
        logic [TAG_W-1:0]  line_tag;
        logic              is_miss;
        logic              replaced_valid;
        logic [TAG_W-1:0]  evicted_tag;
        logic [HCNT_W-1:0] hits_so_far;
        logic [HCNT_W-1:0] misses_so_far;
    } rsp_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_LOOKUP
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic load;
        logic div_step;
        logic rd_en;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== rtl/tlru_req_if.sv =====
interface tlru_req_if;
    logic                          valid;
    logic                          ready;
    logic [tlru_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

// ===== rtl/tlru_rsp_if.sv =====
interface tlru_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tlru_pkg::OFS_W-1:0]    byte_offset;
    logic [tlru_pkg::BLK_W-1:0]    block_number;
    logic [tlru_pkg::SETF_W-1:0]   set_index;
    logic                          way_used;
    logic [tlru_pkg::TAG_W-1:0]    line_tag;
    logic                          is_miss;
    logic                          replaced_valid;
    logic [tlru_pkg::TAG_W-1:0]    evicted_tag;
    logic [tlru_pkg::HCNT_W-1:0]   hits_so_far;
    logic [tlru_pkg::HCNT_W-1:0]   misses_so_far;

    modport source (
        output valid, input ready,
        output byte_offset, output block_number, output set_index, output way_used,
        output line_tag, output is_miss, output replaced_valid, output evicted_tag,
        output hits_so_far, output misses_so_far
    );
    modport sink (
        input valid, output ready,
        input byte_offset, input block_number, input set_index, input way_used,
        input line_tag, input is_miss, input replaced_valid, input evicted_tag,
        input hits_so_far, input misses_so_far
    );
endinterface

// ===== rtl/tlru_ram.sv =====
module tlru_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read that holds until the next read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tlru_ctrl.sv =====
module tlru_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tlru_pkg::dp_status_t   status,
    output tlru_pkg::ctrl_cmd_t    cmd
);

    tlru_pkg::state_t state_reg;
    tlru_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlru_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlru_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = tlru_pkg::ST_IDLE;
                end
            end
            tlru_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tlru_pkg::ST_INDEX;
                end
            end
            tlru_pkg::ST_INDEX:
            begin
                if (status.div_done)
                begin
                    state_next = tlru_pkg::ST_LOOKUP;
                end
            end
            tlru_pkg::ST_LOOKUP:
            begin
                if (!status.out_busy)
                begin
                    state_next = tlru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlru_pkg::ST_CLEAR;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            tlru_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            tlru_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tlru_pkg::ST_INDEX:
            begin
                cmd.rd_en    = status.div_done;
                cmd.div_step = !status.div_done;
            end
            tlru_pkg::ST_LOOKUP:
            begin
                cmd.commit = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/tlru_dp.sv =====
module tlru_dp #(
    parameter int SET_COUNT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tlru_pkg::ADDR_W-1:0]   address,
    input  logic                          out_ready,
    input  tlru_pkg::ctrl_cmd_t           cmd,
    output tlru_pkg::dp_status_t          status,
    output logic                          out_valid,
    output tlru_pkg::rsp_t                rsp
);

    localparam int  IDX_W  = $clog2(SET_COUNT);
    localparam int  MOD_W  = IDX_W + 1;
    localparam int  PROD_W = 2 * tlru_pkg::BLK_W;
    localparam bit  POW2   = (SET_COUNT & (SET_COUNT - 1)) == 0;
    localparam logic [MOD_W-1:0] SETS_EXT  = MOD_W'(SET_COUNT);
    localparam logic [IDX_W-1:0] LAST_SET  = IDX_W'(SET_COUNT - 1);
    // floor(2^27 / SET_COUNT): the quotient estimate is at most one short,
    // so the remainder estimate lies below twice the set count
    localparam logic [tlru_pkg::BLK_W-1:0] RECIP =
        tlru_pkg::BLK_W'((64'd1 << tlru_pkg::BLK_W) / SET_COUNT);

    logic [tlru_pkg::ADDR_W-1:0]   addr_reg;
    logic [tlru_pkg::BLK_W-1:0]    blk_reg;
    logic [tlru_pkg::BLK_W-1:0]    blk_next;
    logic [MOD_W-1:0]              quo_lo_reg;
    logic [MOD_W-1:0]              quo_lo_next;
    logic [MOD_W-1:0]              rem_est_reg;
    logic [MOD_W-1:0]              rem_est_next;
    logic [IDX_W-1:0]              set_reg;
    logic [IDX_W-1:0]              set_next;
    logic [tlru_pkg::DIVCNT_W-1:0] div_cnt_reg;
    logic [tlru_pkg::DIVCNT_W-1:0] div_cnt_next;
    logic [IDX_W-1:0]              clr_cnt_reg;
    logic [tlru_pkg::HCNT_W-1:0]   hit_cnt_reg;
    logic [tlru_pkg::HCNT_W-1:0]   hit_cnt_next;
    logic [tlru_pkg::HCNT_W-1:0]   miss_cnt_reg;
    logic [tlru_pkg::HCNT_W-1:0]   miss_cnt_next;
    logic                          out_valid_reg;
    tlru_pkg::rsp_t                rsp_reg;
    tlru_pkg::rsp_t                rsp_next;

    logic [PROD_W-1:0]             mod_prod;
    logic [MOD_W-1:0]              rem_corr;
    logic [IDX_W+5:0]              set_wide;

    logic [tlru_pkg::ROW_W-1:0]    rd_data;
    tlru_pkg::row_t                row;
    tlru_pkg::row_t                row_new;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [tlru_pkg::ROW_W-1:0]    wr_data;

    logic [tlru_pkg::TAG_W-1:0]    tag;
    logic [1:0]                    filled;
    logic                          hit0;
    logic                          hit1;
    logic                          miss;
    logic                          way;
    logic                          replaced;

    // Set index: block number modulo the set count. A power of two takes the
    // low block bits; otherwise a reciprocal multiply gives the low quotient
    // bits, then the remainder estimate, then one compare and subtract.
    always_comb
    begin
        mod_prod     = PROD_W'(blk_reg) * PROD_W'(RECIP);
        rem_corr     = (rem_est_reg >= SETS_EXT) ? (rem_est_reg - SETS_EXT) : rem_est_reg;
        set_next     = set_reg;
        blk_next     = blk_reg;
        quo_lo_next  = quo_lo_reg;
        rem_est_next = rem_est_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.load)
        begin
            blk_next     = address[tlru_pkg::ADDR_W-1:tlru_pkg::BLK_LSB];
            div_cnt_next = '0;
            if (POW2)
            begin
                set_next = address[tlru_pkg::BLK_LSB +: IDX_W];
            end
            else
            begin
                set_next = '0;
            end
        end
        else if (cmd.div_step)
        begin
            div_cnt_next = div_cnt_reg + 1'b1;
            case (div_cnt_reg)
                tlru_pkg::MOD_QUOT:
                begin
                    quo_lo_next = mod_prod[tlru_pkg::BLK_W +: MOD_W];
                end
                tlru_pkg::MOD_REM:
                begin
                    // only the low bits matter: the true value is below 2 * SET_COUNT
                    rem_est_next = blk_reg[MOD_W-1:0] - quo_lo_reg * SETS_EXT;
                end
                tlru_pkg::MOD_FIX:
                begin
                    set_next = rem_corr[IDX_W-1:0];
                end
                default:
                begin
                    set_next = set_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= address;
        end
        set_reg     <= set_next;
        blk_reg     <= blk_next;
        quo_lo_reg  <= quo_lo_next;
        rem_est_reg <= rem_est_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg   <= '0;
            clr_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_cnt_reg  <= div_cnt_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Tag directory: one row per set holding both ways
    tlru_ram #(
        .WIDTH (tlru_pkg::ROW_W),
        .DEPTH (SET_COUNT)
    ) u_dir (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (set_reg),
        .rd_data (rd_data)
    );

    // Tag compare and LRU victim choice
    always_comb
    begin
        row    = tlru_pkg::row_t'(rd_data);
        tag    = addr_reg[tlru_pkg::ADDR_W-1:tlru_pkg::TAG_LSB];
        filled = (row.filled == 2'd3) ? tlru_pkg::FILL_TWO : row.filled;
        hit0   = (filled != tlru_pkg::FILL_NONE) && (row.tag0 == tag);
        hit1   = !hit0 && (filled == tlru_pkg::FILL_TWO) && (row.tag1 == tag);
        miss   = !(hit0 || hit1);
        replaced = miss && (filled == tlru_pkg::FILL_TWO);

        if (hit0)
        begin
            way = 1'b0;
        end
        else if (hit1)
        begin
            way = 1'b1;
        end
        else if (filled == tlru_pkg::FILL_NONE)
        begin
            way = 1'b0;
        end
        else if (filled == tlru_pkg::FILL_ONE)
        begin
            way = 1'b1;
        end
        else
        begin
            way = !row.recent;
        end

        row_new        = row;
        row_new.recent = way;
        if (miss)
        begin
            if (way)
            begin
                row_new.tag1 = tag;
            end
            else
            begin
                row_new.tag0 = tag;
            end
            if (filled == tlru_pkg::FILL_NONE)
            begin
                row_new.filled = tlru_pkg::FILL_ONE;
            end
            else if (filled == tlru_pkg::FILL_ONE)
            begin
                row_new.filled = tlru_pkg::FILL_TWO;
            end
        end
    end

    // Directory write: clearing sweep after reset, else the lookup update
    always_comb
    begin
        wr_en   = cmd.clr_step || cmd.commit;
        wr_addr = cmd.clr_step ? clr_cnt_reg : set_reg;
        wr_data = cmd.clr_step ? '0 : tlru_pkg::ROW_W'(row_new);
    end

    // Saturating counters
    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (cmd.commit)
        begin
            if (miss && (miss_cnt_reg != tlru_pkg::CNT_MAX))
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
            if (!miss && (hit_cnt_reg != tlru_pkg::CNT_MAX))
            begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
        end
    end

    // Result assembly
    always_comb
    begin
        set_wide                = (IDX_W + 6)'(set_reg);
        rsp_next.byte_offset    = addr_reg[tlru_pkg::OFS_W-1:0];
        rsp_next.block_number   = addr_reg[tlru_pkg::ADDR_W-1:tlru_pkg::BLK_LSB];
        rsp_next.set_index      = set_wide[tlru_pkg::SETF_W-1:0];
        rsp_next.way_used       = way;
        rsp_next.line_tag       = tag;
        rsp_next.is_miss        = miss;
        rsp_next.replaced_valid = replaced;
        rsp_next.evicted_tag    = replaced ? (way ? row.tag1 : row.tag0) : '0;
        rsp_next.hits_so_far    = hit_cnt_next;
        rsp_next.misses_so_far  = miss_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign status.clr_last = (clr_cnt_reg == LAST_SET);
    assign status.div_done = POW2 || (div_cnt_reg == tlru_pkg::MOD_DONE);
    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign rsp             = rsp_reg;

endmodule

// ===== rtl/two_way_lru_cache_tag_lookup.sv =====
// Tag directory for a two-way set-associative cache of SET_COUNT sets with
// 32-byte lines and LRU replacement. Each address item comes back as one
// result item: the address split, the way hit or filled, miss and eviction
// flags with the evicted tag, and saturating hit and miss counts. One item is
// in flight at a time. With a power-of-two SET_COUNT an accepted item goes
// through a directory read, then compare and update, and no new item is
// accepted until it leaves the lookup step; any other SET_COUNT puts the
// set index remainder steps (reciprocal multiply, remainder estimate, one
// correction) before the read. The directory is one RAM row per set; after
// reset a clearing pass zeroes it, during which no item is accepted. A
// finished result waits in an output register, and the next item is accepted
// meanwhile; that item then waits in the lookup step until the result leaves.
module two_way_lru_cache_tag_lookup #(
    parameter int SET_COUNT = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    tlru_req_if.sink     req,
    tlru_rsp_if.source   rsp
);

    tlru_pkg::ctrl_cmd_t  cmd;
    tlru_pkg::dp_status_t status;
    tlru_pkg::rsp_t       rsp_data;
    logic                 in_ready;
    logic                 out_valid;

    // Sequencer
    tlru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Index, directory and counters
    tlru_dp #(
        .SET_COUNT (SET_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .address   (req.address),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .rsp       (rsp_data)
    );

    assign req.ready          = in_ready;
    assign rsp.valid          = out_valid;
    assign rsp.byte_offset    = rsp_data.byte_offset;
    assign rsp.block_number   = rsp_data.block_number;
    assign rsp.set_index      = rsp_data.set_index;
    assign rsp.way_used       = rsp_data.way_used;
    assign rsp.line_tag       = rsp_data.line_tag;
    assign rsp.is_miss        = rsp_data.is_miss;
    assign rsp.replaced_valid = rsp_data.replaced_valid;
    assign rsp.evicted_tag    = rsp_data.evicted_tag;
    assign rsp.hits_so_far    = rsp_data.hits_so_far;
    assign rsp.misses_so_far  = rsp_data.misses_so_far;

endmodule

// ===== rtl/tlru_checker.sv =====
module tlru_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [tlru_pkg::BLK_W-1:0]    block_number,
    input logic [tlru_pkg::TAG_W-1:0]    line_tag,
    input logic                          is_miss,
    input logic                          replaced_valid,
    input logic [tlru_pkg::TAG_W-1:0]    evicted_tag
);

    // A stalled result keeps its tag fields
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(line_tag) && $stable(evicted_tag))
        else $error("stalled result changed");

    // Only one item in flight: no acceptance right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while another is in flight");

    // An eviction happens only on a miss
    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && replaced_valid |-> is_miss)
        else $error("eviction reported on a hit");

    // No eviction means the evicted tag reads zero
    a_evict_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !replaced_valid |-> evicted_tag == '0)
        else $error("evicted tag nonzero without eviction");

    // Tag is the top of the block number
    a_tag_split: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> block_number[tlru_pkg::BLK_W-1:tlru_pkg::SETF_W] == line_tag)
        else $error("tag and block number disagree");

endmodule

bind two_way_lru_cache_tag_lookup tlru_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .block_number   (rsp.block_number),
    .line_tag       (rsp.line_tag),
    .is_miss        (rsp.is_miss),
    .replaced_valid (rsp.replaced_valid),
    .evicted_tag    (rsp.evicted_tag)
);

// ===== dv/two_way_lru_cache_tag_lookup_tb.sv =====
module two_way_lru_cache_tag_lookup_tb;

    localparam int NUM_SETS        = 64;
    localparam int RANDOM_ITEMS    = 1200;
    localparam int DRAIN_AT_ITEM   = 600;
    localparam int HOLD_AT_RESULT  = 300;
    localparam int HOLD_CYCLES     = 150;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int DIRECTED_ROWS   = 19;

    // Directed stimulus row: address, plus a hand-written expectation when known
    typedef struct {
        logic [tlru_pkg::ADDR_W-1:0] address;
        bit                          typed;
        tlru_pkg::rsp_t              want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tlru_req_if req ();
    tlru_rsp_if rsp ();

    two_way_lru_cache_tag_lookup #(
        .SET_COUNT (NUM_SETS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Predictor state: way tags, fill count and MRU way per set, running counts
    logic [tlru_pkg::TAG_W-1:0]  dir_tag [NUM_SETS][2];
    logic [1:0]                  dir_fill [NUM_SETS];
    logic                        dir_mru [NUM_SETS];
    logic [tlru_pkg::HCNT_W-1:0] hit_count;
    logic [tlru_pkg::HCNT_W-1:0] miss_count;

    tlru_pkg::rsp_t lookups_due [$];
    int             fail_count;
    int             results_checked;
    int             idle_cycles;

    // Order of fields: offset, block, set, way, tag, miss, replaced, evicted, hits, misses
    stim_row_t stim_rows [DIRECTED_ROWS] = '{
        // empty set 0: fill way 0
        '{32'h0000_0000, 1'b1, '{5'd0, 27'd0, 6'd0, 1'b0, 21'd0, 1'b1, 1'b0, 21'd0,
                                 32'd0, 32'd1}},
        // all ones: top set, top tag
        '{32'hFFFF_FFFF, 1'b1, '{5'h1F, 27'h7FF_FFFF, 6'h3F, 1'b0, 21'h1F_FFFF, 1'b1, 1'b0,
                                 21'd0, 32'd0, 32'd2}},
        // same line, last byte: hit way 0
        '{32'h0000_001F, 1'b1, '{5'h1F, 27'd0, 6'd0, 1'b0, 21'd0, 1'b0, 1'b0, 21'd0,
                                 32'd1, 32'd2}},
        // one way filled: fill way 1
        '{32'h0000_0800, 1'b1, '{5'd0, 27'h40, 6'd0, 1'b1, 21'd1, 1'b1, 1'b0, 21'd0,
                                 32'd1, 32'd3}},
        // full set, way 1 recent: evict way 0 (tag 0)
        '{32'h0000_1000, 1'b1, '{5'd0, 27'h80, 6'd0, 1'b0, 21'd2, 1'b1, 1'b1, 21'd0,
                                 32'd1, 32'd4}},
        // hit way 1
        '{32'h0000_0800, 1'b1, '{5'd0, 27'h40, 6'd0, 1'b1, 21'd1, 1'b0, 1'b0, 21'd0,
                                 32'd2, 32'd4}},
        // evict way 0 (tag 2)
        '{32'h0000_1800, 1'b1, '{5'd0, 27'hC0, 6'd0, 1'b0, 21'd3, 1'b1, 1'b1, 21'd2,
                                 32'd2, 32'd5}},
        // evict way 1 (tag 1)
        '{32'h0000_1000, 1'b1, '{5'd0, 27'h80, 6'd0, 1'b1, 21'd2, 1'b1, 1'b1, 21'd1,
                                 32'd2, 32'd6}},
        // top set hit, offset 0
        '{32'hFFFF_FFE0, 1'b1, '{5'd0, 27'h7FF_FFFF, 6'h3F, 1'b0, 21'h1F_FFFF, 1'b0, 1'b0,
                                 21'd0, 32'd3, 32'd6}},
        '{32'hFFFF_F800, 1'b0, '0},
        '{32'h0000_07E0, 1'b0, '0},
        '{32'h0000_0FE0, 1'b0, '0},
        '{32'hFFFF_FFE5, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{32'h8000_0000, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, '0},
        '{32'h0000_1010, 1'b0, '0},
        '{32'h0000_0000, 1'b0, '0}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Lookup and update of the predicted directory for one address
    function automatic tlru_pkg::rsp_t predict_lookup(logic [tlru_pkg::ADDR_W-1:0] address);
        tlru_pkg::rsp_t             r;
        logic [5:0]                 set;
        logic [tlru_pkg::TAG_W-1:0] tag;
        logic [1:0]                 filled;
        begin
            r                = '0;
            set              = address[10:5];
            tag              = address[31:11];
            filled           = (dir_fill[set] > tlru_pkg::FILL_TWO) ? tlru_pkg::FILL_TWO
                                                                     : dir_fill[set];
            r.byte_offset    = address[4:0];
            r.block_number   = address[31:5];
            r.set_index      = set;
            r.line_tag       = tag;
            r.is_miss        = 1'b1;
            if (filled >= tlru_pkg::FILL_ONE && dir_tag[set][0] == tag)
            begin
                r.is_miss  = 1'b0;
                r.way_used = 1'b0;
            end
            else if (filled == tlru_pkg::FILL_TWO && dir_tag[set][1] == tag)
            begin
                r.is_miss  = 1'b0;
                r.way_used = 1'b1;
            end
            if (r.is_miss)
            begin
                if (filled == tlru_pkg::FILL_NONE)
                begin
                    r.way_used    = 1'b0;
                    dir_fill[set] = tlru_pkg::FILL_ONE;
                end
                else if (filled == tlru_pkg::FILL_ONE)
                begin
                    r.way_used    = 1'b1;
                    dir_fill[set] = tlru_pkg::FILL_TWO;
                end
                else
                begin
                    // full set: the way not most recently used goes
                    r.way_used       = ~dir_mru[set];
                    r.replaced_valid = 1'b1;
                    r.evicted_tag    = dir_tag[set][r.way_used];
                end
                dir_tag[set][r.way_used] = tag;
                if (miss_count != tlru_pkg::CNT_MAX)
                    miss_count = miss_count + 1'b1;
            end
            else if (hit_count != tlru_pkg::CNT_MAX)
            begin
                hit_count = hit_count + 1'b1;
            end
            dir_mru[set]    = r.way_used;
            r.hits_so_far   = hit_count;
            r.misses_so_far = miss_count;
            return r;
        end
    endfunction

    // Offer one address; on acceptance record what it should produce
    task automatic send_address(logic [tlru_pkg::ADDR_W-1:0] address, bit typed,
                                tlru_pkg::rsp_t want);
        tlru_pkg::rsp_t predicted;
        begin
            req.valid   <= 1'b1;
            req.address <= address;
            @(posedge clk);
            while (!req.ready)
                @(posedge clk);
            predicted = predict_lookup(address);
            lookups_due.push_back(typed ? want : predicted);
            @(negedge clk);
        end
    endtask

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        begin
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", fname, want, got);
                fail_count++;
            end
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        tlru_pkg::rsp_t want;
        if (rsp.valid && rsp.ready)
        begin
            if (lookups_due.size() == 0)
            begin
                $error("result item with nothing outstanding");
                fail_count++;
            end
            else
            begin
                want = lookups_due.pop_front();
                check_field("byte_offset", want.byte_offset, rsp.byte_offset);
                check_field("block_number", want.block_number, rsp.block_number);
                check_field("set_index", want.set_index, rsp.set_index);
                check_field("way_used", want.way_used, rsp.way_used);
                check_field("line_tag", want.line_tag, rsp.line_tag);
                check_field("is_miss", want.is_miss, rsp.is_miss);
                check_field("replaced_valid", want.replaced_valid, rsp.replaced_valid);
                check_field("evicted_tag", want.evicted_tag, rsp.evicted_tag);
                check_field("hits_so_far", want.hits_so_far, rsp.hits_so_far);
                check_field("misses_so_far", want.misses_so_far, rsp.misses_so_far);
            end
            results_checked++;
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("two_way_lru_cache_tag_lookup_tb NOT OK");
            $finish;
        end
    end

    // Result side: random stall modes, each held for a random run, and one long hold-off
    initial
    begin
        int  mode;
        int  mode_left;
        int  phase;
        bit  hold_done;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        hold_done = 1'b0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_checked >= HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase++;
            case (mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= 1'($urandom_range(0, 1));
                2: rsp.ready <= ($urandom_range(0, 3) == 0);
                default: rsp.ready <= (phase % 5 != 0);
            endcase
        end
    end

    // Stimulus
    initial
    begin
        logic [tlru_pkg::TAG_W-1:0]  tag_pool [4];
        logic [tlru_pkg::ADDR_W-1:0] address;
        int                          burst_left;
        int                          gap;
        int                          pick;
        fail_count      = 0;
        results_checked = 0;
        idle_cycles     = 0;
        hit_count       = '0;
        miss_count      = '0;
        for (int s = 0; s < NUM_SETS; s++)
        begin
            dir_fill[s]   = tlru_pkg::FILL_NONE;
            dir_mru[s]    = 1'b0;
            dir_tag[s][0] = '0;
            dir_tag[s][1] = '0;
        end
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.address = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed rows, back to back
        foreach (stim_rows[i])
            send_address(stim_rows[i].address, stim_rows[i].typed, stim_rows[i].want);

        // random part: a pool of four hot tags, shared by all sets, gives hits and LRU evictions
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 200 == 0)
                foreach (tag_pool[k])
                    tag_pool[k] = tlru_pkg::TAG_W'($urandom());
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                address = $urandom();
            end
            else
            begin
                address[31:11] = tag_pool[$urandom_range(0, 3)];
                address[10:5]  = (pick < 5) ? 6'($urandom_range(0, 3))
                                            : 6'($urandom_range(0, NUM_SETS - 1));
                address[4:0]   = 5'($urandom_range(0, 31));
            end
            send_address(address, 1'b0, '0);

            if (n == DRAIN_AT_ITEM)
            begin
                // sender stands still until every result is back
                req.valid <= 1'b0;
                while (lookups_due.size() != 0)
                    @(negedge clk);
            end
            else if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                         : $urandom_range(1, 24);
                if (gap != 0)
                begin
                    req.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            else
            begin
                burst_left--;
            end
        end

        req.valid <= 1'b0;
        while (lookups_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("two_way_lru_cache_tag_lookup_tb OK");
        else
            $display("two_way_lru_cache_tag_lookup_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tlru_pkg.sv
rtl/tlru_req_if.sv
rtl/tlru_rsp_if.sv
rtl/tlru_ram.sv
rtl/tlru_ctrl.sv
rtl/tlru_dp.sv
rtl/two_way_lru_cache_tag_lookup.sv
rtl/tlru_checker.sv
dv/two_way_lru_cache_tag_lookup_tb.sv
